[hdl/mbpq_pkg.sv]
package mbpq_pkg;

  localparam int DefBins = 8;
  localparam int DefBinCapacity = 64;
  localparam int DefPriorityWidth = 16;

  localparam int KindW = 1;
  localparam int BinW = 3;
  localparam int PrioW = 16;
  localparam int StatusW = 2;

  localparam logic [KindW-1:0] KIND_PUT = 1'b0;
  localparam logic [KindW-1:0] KIND_TAKE = 1'b1;

  localparam logic [StatusW-1:0] ST_PUT_OK = 2'd0;
  localparam logic [StatusW-1:0] ST_TAKEN = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL = 2'd3;

endpackage

[hdl/multi_bin_priority_queue_core.sv]
// Binned min-heap priority queue. A put request inserts a priority into the
// heap of the named bin; a take request removes the smallest priority of the
// bin whose minimum is smallest overall, ties going to the lower bin. A put or
// take that changes a heap keeps the block busy while the heap sift runs
// through the heap memory's registered read ports, and then while one
// comparator walks the bin minima one bin per cycle. A put into a full or
// out-of-range bin, or a take from an empty queue, skips the heap and the
// walk. The block is not ready while a request is in progress. The result
// waits in an output register and the next request is accepted while it
// waits; that request stalls in its done state until the earlier result is
// taken. Heap memory contents are undefined after reset.
module multi_bin_priority_queue_core
  import mbpq_pkg::*;
#(
  parameter int BINS = DefBins,
  parameter int BIN_CAPACITY = DefBinCapacity,
  parameter int PRIORITY_WIDTH = DefPriorityWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KindW-1:0]   kind,
  input  logic [BinW-1:0]    bin,
  input  logic [PrioW-1:0]   priority_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [StatusW-1:0] status,
  output logic [PrioW-1:0]   taken_priority,
  output logic [BinW-1:0]    taken_bin
);

  localparam int BinIdxW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int SlotW = $clog2(BIN_CAPACITY);
  localparam int CntW = $clog2(BIN_CAPACITY + 1);
  localparam int AddrW = ((BINS * BIN_CAPACITY) > 1) ? $clog2(BINS * BIN_CAPACITY) : 1;
  localparam int MinW = PRIORITY_WIDTH + 1;
  localparam logic [MinW-1:0] EmptyMark = {1'b1, {PRIORITY_WIDTH{1'b0}}};
  localparam logic [BinIdxW-1:0] LastBin = BinIdxW'(BINS - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_UREAD = 11'b00000000010,
    S_UCMP  = 11'b00000000100,
    S_UFIN  = 11'b00000001000,
    S_LAST  = 11'b00000010000,
    S_LGET  = 11'b00000100000,
    S_DREAD = 11'b00001000000,
    S_DCMP  = 11'b00010000000,
    S_DFIN  = 11'b00100000000,
    S_SCAN  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;
  logic [CntW-1:0] bin_count [BINS];
  logic [MinW-1:0] bin_minimum [BINS];
  logic [BinIdxW-1:0] best_bin;
  logic best_valid;

  logic [BinIdxW-1:0] cur_bin;
  logic [SlotW-1:0] idx;
  logic [CntW-1:0] cnt;
  logic [PRIORITY_WIDTH-1:0] val;
  logic [PRIORITY_WIDTH-1:0] root;
  logic [PRIORITY_WIDTH-1:0] top;
  logic [StatusW-1:0] op_status;
  logic [BinIdxW-1:0] scan;
  logic [MinW-1:0] least;
  logic [BinIdxW-1:0] least_bin;
  logic least_valid;

  logic we;
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;
  logic [PRIORITY_WIDTH-1:0] wdata, rdata_a, rdata_b;

  logic [StatusW-1:0] status_r;
  logic [PRIORITY_WIDTH-1:0] tprio_r;
  logic [BinIdxW-1:0] tbin_r;
  logic out_full;
  logic load_out;

  mbpq_heap_mem #(
    .Depth(BINS * BIN_CAPACITY),
    .Width(PRIORITY_WIDTH)
  ) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rdata_a), .rdata_b(rdata_b)
  );

  function automatic logic [AddrW-1:0] addr_of(logic [BinIdxW-1:0] b,
                                               logic [SlotW-1:0] s);
    logic [AddrW+SlotW:0] a;
    a = (AddrW + SlotW + 1)'(b) * (AddrW + SlotW + 1)'(BIN_CAPACITY)
        + (AddrW + SlotW + 1)'(s);
    return a[AddrW-1:0];
  endfunction

  logic [SlotW-1:0] parent, lchild, rchild;
  logic [CntW:0] lchild_w, rchild_w;
  logic has_child, pick_right;
  logic up_move, down_move;
  logic [BinIdxW-1:0] in_bin_idx;
  logic in_bin_ok;
  logic [CntW-1:0] in_cnt;
  logic [PRIORITY_WIDTH-1:0] in_prio;
  logic [PRIORITY_WIDTH-1:0] pick;
  logic [SlotW-1:0] pick_idx;
  logic cand_less;

  assign in_ready = (state == S_IDLE);
  assign parent = SlotW'((idx - SlotW'(1)) >> 1);
  assign lchild_w = ((CntW + 1)'(idx) << 1) + (CntW + 1)'(1);
  assign rchild_w = lchild_w + (CntW + 1)'(1);
  assign lchild = lchild_w[SlotW-1:0];
  assign rchild = rchild_w[SlotW-1:0];
  assign has_child = lchild_w < {1'b0, cnt};
  assign pick_right = (rchild_w < {1'b0, cnt}) && (rdata_b < rdata_a);
  assign pick = pick_right ? rdata_b : rdata_a;
  assign pick_idx = pick_right ? rchild : lchild;
  assign up_move = rdata_a > val;
  assign down_move = pick < val;
  assign in_bin_idx = BinIdxW'(bin);
  assign in_bin_ok = ({{(32-BinW){1'b0}}, bin} < BINS);
  assign in_cnt = bin_count[in_bin_idx];
  assign in_prio = PRIORITY_WIDTH'(priority_req);
  assign cand_less = bin_minimum[scan] < least;
  assign load_out = (state == S_DONE) && (!out_full || out_ready);

  always_comb begin
    we = 1'b0;
    waddr = addr_of(cur_bin, idx);
    wdata = val;
    raddr_a = addr_of(cur_bin, lchild);
    raddr_b = addr_of(cur_bin, rchild);
    unique case (state)
      S_UREAD: raddr_a = addr_of(cur_bin, parent);
      S_UCMP: begin
        if (up_move) begin
          we = 1'b1;
          wdata = rdata_a;
        end
      end
      S_UFIN, S_DFIN: we = 1'b1;
      S_LAST: raddr_a = addr_of(cur_bin, SlotW'(cnt));
      S_DCMP: begin
        if (down_move) begin
          we = 1'b1;
          wdata = pick;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      best_valid <= 1'b0;
      best_bin <= '0;
      for (int b = 0; b < BINS; b++) begin
        bin_count[b] <= '0;
        bin_minimum[b] <= EmptyMark;
      end
    end else begin
      out_full <= load_out || (out_full && !out_ready);
      if (load_out) begin
        status_r <= op_status;
        tprio_r <= (op_status == ST_TAKEN) ? top : '0;
        tbin_r <= (op_status == ST_TAKEN) ? cur_bin : '0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            scan <= '0;
            least <= EmptyMark;
            least_valid <= 1'b0;
            least_bin <= '0;
            if (kind == KIND_PUT) begin
              if (!in_bin_ok || in_cnt >= CntW'(BIN_CAPACITY)) begin
                op_status <= ST_FULL;
                state <= S_DONE;
              end else begin
                op_status <= ST_PUT_OK;
                cur_bin <= in_bin_idx;
                val <= in_prio;
                idx <= in_cnt[SlotW-1:0];
                bin_count[in_bin_idx] <= in_cnt + CntW'(1);
                if ({1'b0, in_prio} < bin_minimum[in_bin_idx]) begin
                  bin_minimum[in_bin_idx] <= {1'b0, in_prio};
                end
                state <= (in_cnt == '0) ? S_UFIN : S_UREAD;
              end
            end else begin
              if (!best_valid || bin_count[best_bin] == '0) begin
                op_status <= ST_EMPTY;
                state <= S_DONE;
              end else begin
                op_status <= ST_TAKEN;
                cur_bin <= best_bin;
                cnt <= bin_count[best_bin] - CntW'(1);
                bin_count[best_bin] <= bin_count[best_bin] - CntW'(1);
                top <= bin_minimum[best_bin][PRIORITY_WIDTH-1:0];
                idx <= '0;
                if (bin_count[best_bin] == CntW'(1)) begin
                  bin_minimum[best_bin] <= EmptyMark;
                  state <= S_SCAN;
                end else begin
                  state <= S_LAST;
                end
              end
            end
          end
        end
        S_UREAD: state <= S_UCMP;
        S_UCMP: begin
          if (up_move) begin
            idx <= parent;
            state <= (parent == '0) ? S_UFIN : S_UREAD;
          end else begin
            state <= S_UFIN;
          end
        end
        S_UFIN: state <= S_SCAN;
        S_LAST: state <= S_LGET;
        S_LGET: begin
          val <= rdata_a;
          state <= has_child ? S_DCMP : S_DFIN;
        end
        S_DREAD: state <= has_child ? S_DCMP : S_DFIN;
        S_DCMP: begin
          if (down_move) begin
            idx <= pick_idx;
            if (idx == '0) begin
              root <= pick;
            end
            state <= S_DREAD;
          end else begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          bin_minimum[cur_bin] <= {1'b0, (idx == '0) ? val : root};
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan == LastBin) begin
            best_bin <= cand_less ? scan : least_bin;
            best_valid <= cand_less || least_valid;
            state <= S_DONE;
          end else begin
            if (cand_less) begin
              least <= bin_minimum[scan];
              least_bin <= scan;
              least_valid <= 1'b1;
            end
            scan <= scan + BinIdxW'(1);
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_full;
  assign status = status_r;
  assign taken_priority = PrioW'(tprio_r);
  assign taken_bin = BinW'(tbin_r);

  property p_ready_idle;
    @(posedge clk) disable iff (rst) in_ready |-> state == S_IDLE;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

  property p_taken_fields;
    @(posedge clk) disable iff (rst)
      (out_valid && status != ST_TAKEN) |-> taken_priority == '0 && taken_bin == '0;
  endproperty
  a_taken_fields: assert property (p_taken_fields) else $error("nonzero fields");

  property p_best_valid;
    @(posedge clk) disable iff (rst)
      (state == S_IDLE && best_valid) |-> bin_count[best_bin] != '0;
  endproperty
  a_best_valid: assert property (p_best_valid) else $error("best bin empty");

  property p_out_hold;
    @(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=> out_valid && $stable(status)
        && $stable(taken_priority) && $stable(taken_bin);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while waiting");

endmodule

[hdl/mbpq_heap_mem.sv]
module mbpq_heap_mem
  import mbpq_pkg::*;
#(
  parameter int Depth = DefBins * DefBinCapacity,
  parameter int Width = DefPriorityWidth,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr_a,
  input  logic [AddrW-1:0] raddr_b,
  output logic [Width-1:0] rdata_a,
  output logic [Width-1:0] rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
